/* src/oale_pkg.sv */
// Shared definitions for the ordered array list engine: field widths,
// request mode and status codes, controller states and the stored entry type.
// No dependencies.
`default_nettype none

package oale_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int KEY_W   = 32;
    localparam int PAY_W   = 64;
    localparam int POS_W   = 6;
    localparam int MODE_W  = 4;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_FRONT = 4'd0,
        MODE_INS_BACK  = 4'd1,
        MODE_INS_POS   = 4'd2,
        MODE_FIND_KEY  = 4'd3,
        MODE_READ_POS  = 4'd4,
        MODE_RM_FRONT  = 4'd5,
        MODE_RM_BACK   = 4'd6,
        MODE_RM_POS    = 4'd7,
        MODE_RM_KEY    = 4'd8,
        MODE_CLEAR     = 4'd9
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL_MT  = 2'd1,
        STAT_NO_KEY   = 2'd2,
        STAT_BAD_POS  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE,
        S_PUT,
        S_FETCH
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } entry_t;

endpackage

`default_nettype wire

/* src/ordered_array_list_engine.sv */
// Ordered array list engine top level: request decode, sweep controller and
// result registers. Depends on oale_pkg and oale_ram.
//
//  channel   | handshake                     | fields
//  ----------+-------------------------------+-----------------------------------------
//  request   | start & !busy at rising edge  | mode, record_key, record_payload, position
//  result    | done high for one cycle       | status, found_key, found_payload, entry_count
//
// Steps: a request that needs no memory access (clear, remove at back, remove of
// the last entry, an unused mode, any full, empty or bad-position case) gives its
// result in the cycle after it is taken. Read at position reads the entry, then
// registers it (FETCH). Insert shifts the entries from the target up (MOVE), then
// writes the new entry (PUT); an append only writes. Remove at front or position
// shifts the later entries down; find scans from the front; remove by key scans
// from the back and then shifts. Every entry move or key compare goes through the
// single read port of the entry store, one entry per cycle.
// The next request can be taken in the cycle that carries done.
// Reset: rst_n clears the entry count and the controller; the entry store
// is not cleared, since only entries below the count are ever read.
// The receiver cannot stall: each result is valid for the done cycle only.
`default_nettype none

module ordered_array_list_engine #(
    parameter int CAPACITY = oale_pkg::CAPACITY_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output      logic                              busy,
    input  wire logic [oale_pkg::MODE_W-1:0]       mode,
    input  wire logic signed [oale_pkg::KEY_W-1:0] record_key,
    input  wire logic [oale_pkg::PAY_W-1:0]        record_payload,
    input  wire logic [oale_pkg::POS_W-1:0]        position,
    output      logic                              done,
    output      logic [oale_pkg::STAT_W-1:0]       status,
    output      logic signed [oale_pkg::KEY_W-1:0] found_key,
    output      logic [oale_pkg::PAY_W-1:0]        found_payload,
    output      logic [oale_pkg::COUNT_W-1:0]      entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > oale_pkg::POS_W) ? CW : oale_pkg::POS_W;

    // Controller state
    oale_pkg::state_t state_reg, state_next;

    // Control registers
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] ptr_reg, ptr_next;       // next address to read in a sweep
    logic [CW-1:0] left_reg, left_next;     // reads still to issue
    logic          rd_vld_reg;              // a read was issued last cycle
    logic [AW-1:0] rd_addr_reg;             // address of that read
    logic          done_reg, done_next;

    // Request and result holding registers
    logic [oale_pkg::MODE_W-1:0]  op_reg, op_next;
    logic [oale_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [oale_pkg::PAY_W-1:0]   pay_reg, pay_next;
    logic [AW-1:0]                at_reg, at_next;
    logic [oale_pkg::STAT_W-1:0]  status_reg, status_next;
    logic [oale_pkg::KEY_W-1:0]   fkey_reg, fkey_next;
    logic [oale_pkg::PAY_W-1:0]   fpay_reg, fpay_next;

    // Store ports
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    oale_pkg::entry_t rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    oale_pkg::entry_t wr_data;

    // Decode helpers
    logic          cnt_zero;
    logic          cnt_full;
    logic          pos_gt;
    logic          pos_ge;
    logic [AW-1:0] ins_at;
    logic [CW-1:0] up_moves;
    logic [AW-1:0] dn_at;
    logic [CW-1:0] dn_moves;
    logic          key_hit;
    logic          scan_miss_end;
    logic          move_end;
    logic          op_is_ins;

    oale_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign busy = (state_reg != oale_pkg::S_IDLE);

    assign cnt_zero = (count_reg == '0);
    assign cnt_full = (count_reg == CW'(CAPACITY));
    assign pos_gt   = (XW'(position) >  XW'(count_reg));
    assign pos_ge   = (XW'(position) >= XW'(count_reg));

    // Insert target: front, back or the given position
    always_comb
    begin
        case (mode)
            oale_pkg::MODE_INS_FRONT: ins_at = '0;
            oale_pkg::MODE_INS_BACK:  ins_at = AW'(count_reg);
            default:                  ins_at = AW'(position);
        endcase
    end

    assign up_moves = count_reg - CW'(ins_at);

    // Removal target: the scan hit, or front / position on a fresh request
    always_comb
    begin
        if (state_reg == oale_pkg::S_SCAN)
        begin
            dn_at = rd_addr_reg;
        end
        else if (mode == oale_pkg::MODE_RM_POS)
        begin
            dn_at = AW'(position);
        end
        else
        begin
            dn_at = '0;
        end
    end

    assign dn_moves = count_reg - CW'(1) - CW'(dn_at);

    assign key_hit       = rd_vld_reg && (rd_data.key == key_reg);
    assign scan_miss_end = rd_vld_reg && !key_hit && (left_reg == '0);
    assign move_end      = rd_vld_reg && (left_reg == '0);
    assign op_is_ins     = (op_reg == oale_pkg::MODE_INS_FRONT) ||
                           (op_reg == oale_pkg::MODE_INS_BACK)  ||
                           (op_reg == oale_pkg::MODE_INS_POS);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            oale_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (mode)
                        oale_pkg::MODE_INS_FRONT,
                        oale_pkg::MODE_INS_BACK,
                        oale_pkg::MODE_INS_POS:
                        begin
                            if (cnt_full ||
                                ((mode == oale_pkg::MODE_INS_POS) && pos_gt))
                            begin
                                state_next = oale_pkg::S_IDLE;
                            end
                            else if (up_moves == '0)
                            begin
                                state_next = oale_pkg::S_PUT;
                            end
                            else
                            begin
                                state_next = oale_pkg::S_MOVE;
                            end
                        end
                        oale_pkg::MODE_FIND_KEY,
                        oale_pkg::MODE_RM_KEY:
                        begin
                            if (!cnt_zero)
                            begin
                                state_next = oale_pkg::S_SCAN;
                            end
                        end
                        oale_pkg::MODE_READ_POS:
                        begin
                            if (!cnt_zero && !pos_ge)
                            begin
                                state_next = oale_pkg::S_FETCH;
                            end
                        end
                        oale_pkg::MODE_RM_FRONT,
                        oale_pkg::MODE_RM_POS:
                        begin
                            if (!cnt_zero &&
                                !((mode == oale_pkg::MODE_RM_POS) && pos_ge) &&
                                (dn_moves != '0))
                            begin
                                state_next = oale_pkg::S_MOVE;
                            end
                        end
                        default:
                        begin
                            state_next = oale_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            oale_pkg::S_SCAN:
            begin
                if (key_hit)
                begin
                    if ((op_reg == oale_pkg::MODE_RM_KEY) && (dn_moves != '0))
                    begin
                        state_next = oale_pkg::S_MOVE;
                    end
                    else
                    begin
                        state_next = oale_pkg::S_IDLE;
                    end
                end
                else if (scan_miss_end)
                begin
                    state_next = oale_pkg::S_IDLE;
                end
            end
            oale_pkg::S_MOVE:
            begin
                if (move_end)
                begin
                    state_next = op_is_ins ? oale_pkg::S_PUT : oale_pkg::S_IDLE;
                end
            end
            oale_pkg::S_PUT:   state_next = oale_pkg::S_IDLE;
            oale_pkg::S_FETCH: state_next = oale_pkg::S_IDLE;
            default:           state_next = oale_pkg::S_IDLE;
        endcase
    end

    // Datapath, store access and result
    always_comb
    begin
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        left_next   = left_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        pay_next    = pay_reg;
        at_next     = at_reg;
        done_next   = 1'b0;
        status_next = oale_pkg::STAT_OK;
        fkey_next   = '0;
        fpay_next   = '0;
        rd_en       = 1'b0;
        rd_addr     = ptr_reg;
        wr_en       = 1'b0;
        wr_addr     = at_reg;
        wr_data     = rd_data;

        case (state_reg)
            oale_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next  = mode;
                    key_next = $unsigned(record_key);
                    pay_next = record_payload;
                    case (mode)
                        oale_pkg::MODE_INS_FRONT,
                        oale_pkg::MODE_INS_BACK,
                        oale_pkg::MODE_INS_POS:
                        begin
                            if (cnt_full)
                            begin
                                done_next   = 1'b1;
                                status_next = oale_pkg::STAT_FULL_MT;
                            end
                            else if ((mode == oale_pkg::MODE_INS_POS) && pos_gt)
                            begin
                                done_next   = 1'b1;
                                status_next = oale_pkg::STAT_BAD_POS;
                            end
                            else
                            begin
                                // shift up from the top entry down to the target
                                at_next   = ins_at;
                                ptr_next  = AW'(count_reg - CW'(1));
                                left_next = up_moves;
                            end
                        end
                        oale_pkg::MODE_FIND_KEY:
                        begin
                            if (cnt_zero)
                            begin
                                done_next   = 1'b1;
                                status_next = oale_pkg::STAT_FULL_MT;
                            end
                            else
                            begin
                                ptr_next  = '0;
                                left_next = count_reg;
                            end
                        end
                        oale_pkg::MODE_RM_KEY:
                        begin
                            if (cnt_zero)
                            begin
                                done_next   = 1'b1;
                                status_next = oale_pkg::STAT_FULL_MT;
                            end
                            else
                            begin
                                // scan from the back: first hit is the last match
                                ptr_next  = AW'(count_reg - CW'(1));
                                left_next = count_reg;
                            end
                        end
                        oale_pkg::MODE_READ_POS:
                        begin
                            if (cnt_zero)
                            begin
                                done_next   = 1'b1;
                                status_next = oale_pkg::STAT_FULL_MT;
                            end
                            else if (pos_ge)
                            begin
                                done_next   = 1'b1;
                                status_next = oale_pkg::STAT_BAD_POS;
                            end
                            else
                            begin
                                rd_en   = 1'b1;
                                rd_addr = AW'(position);
                            end
                        end
                        oale_pkg::MODE_RM_FRONT,
                        oale_pkg::MODE_RM_POS:
                        begin
                            if (cnt_zero)
                            begin
                                done_next   = 1'b1;
                                status_next = oale_pkg::STAT_FULL_MT;
                            end
                            else if ((mode == oale_pkg::MODE_RM_POS) && pos_ge)
                            begin
                                done_next   = 1'b1;
                                status_next = oale_pkg::STAT_BAD_POS;
                            end
                            else if (dn_moves == '0)
                            begin
                                done_next  = 1'b1;
                                count_next = count_reg - CW'(1);
                            end
                            else
                            begin
                                ptr_next  = dn_at + AW'(1);
                                left_next = dn_moves;
                            end
                        end
                        oale_pkg::MODE_RM_BACK:
                        begin
                            done_next = 1'b1;
                            if (cnt_zero)
                            begin
                                status_next = oale_pkg::STAT_FULL_MT;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        oale_pkg::MODE_CLEAR:
                        begin
                            done_next  = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            oale_pkg::S_SCAN:
            begin
                if ((left_reg != '0) && !key_hit)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = ptr_reg;
                    left_next = left_reg - CW'(1);
                    if (op_reg == oale_pkg::MODE_RM_KEY)
                    begin
                        ptr_next = ptr_reg - AW'(1);
                    end
                    else
                    begin
                        ptr_next = ptr_reg + AW'(1);
                    end
                end
                if (key_hit)
                begin
                    if (op_reg == oale_pkg::MODE_FIND_KEY)
                    begin
                        done_next = 1'b1;
                        fkey_next = rd_data.key;
                        fpay_next = rd_data.payload;
                    end
                    else if (dn_moves == '0)
                    begin
                        done_next  = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                    else
                    begin
                        // close the gap left by the hit
                        ptr_next  = rd_addr_reg + AW'(1);
                        left_next = dn_moves;
                    end
                end
                else if (scan_miss_end)
                begin
                    done_next   = 1'b1;
                    status_next = oale_pkg::STAT_NO_KEY;
                end
            end
            oale_pkg::S_MOVE:
            begin
                if (left_reg != '0)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = ptr_reg;
                    left_next = left_reg - CW'(1);
                    ptr_next  = op_is_ins ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));
                end
                if (rd_vld_reg)
                begin
                    // write back the entry read last cycle one slot over
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                    wr_addr = op_is_ins ? (rd_addr_reg + AW'(1)) : (rd_addr_reg - AW'(1));
                end
                if (move_end && !op_is_ins)
                begin
                    done_next  = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            oale_pkg::S_PUT:
            begin
                wr_en       = 1'b1;
                wr_addr     = at_reg;
                wr_data.key     = key_reg;
                wr_data.payload = pay_reg;
                done_next   = 1'b1;
                count_next  = count_reg + CW'(1);
            end
            oale_pkg::S_FETCH:
            begin
                done_next = 1'b1;
                fkey_next = rd_data.key;
                fpay_next = rd_data.payload;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= oale_pkg::S_IDLE;
            count_reg  <= '0;
            ptr_reg    <= '0;
            left_reg   <= '0;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ptr_reg    <= ptr_next;
            left_reg   <= left_next;
            rd_vld_reg <= rd_en;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        pay_reg    <= pay_next;
        at_reg     <= at_next;
        status_reg <= status_next;
        fkey_reg   <= fkey_next;
        fpay_reg   <= fpay_next;
        if (rd_en)
        begin
            rd_addr_reg <= rd_addr;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign found_key     = $signed(fkey_reg);
    assign found_payload = fpay_reg;
    assign entry_count   = oale_pkg::COUNT_W'(count_reg);

endmodule

`default_nettype wire

/* src/oale_ram.sv */
// Entry store of the ordered array list engine: one write port, one read
// port, read data registered. Depends on oale_pkg (entry_t).
`default_nettype none

module oale_ram #(
    parameter int DEPTH = oale_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(oale_pkg::CAPACITY_DEF)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire oale_pkg::entry_t  wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output oale_pkg::entry_t       rd_data
);

    oale_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* dv/ordered_array_list_engine_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for the ordered array list engine: directed corner requests, then
// phased random traffic, every result checked against an in-bench model of the list.
// Depends on oale_pkg and ordered_array_list_engine.

module ordered_array_list_engine_test;
    import oale_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int ITEM_TOTAL   = 1450;
    localparam int TAIL_ITEMS   = 150;   // last requests go in back to back
    localparam int IDLE_MAX     = 18;
    localparam int KEY_POOL     = 8;
    localparam int REPORT_MAX   = 10;
    // A full-list shift or scan plus the result register, with margin.
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
    // Slowest correct run is near 1500 requests, each with a full-list scan and shift
    // plus an idle burst; allow roughly ten times that.
    localparam longint LIMIT_NS = 64'd20_000_000;
    localparam logic [MODE_W-1:0] MODE_TOP = '1;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        logic [PAY_W-1:0]  payload;
        logic [POS_W-1:0]  pos;
    } list_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [KEY_W-1:0]   key;
        logic [PAY_W-1:0]   payload;
        logic [COUNT_W-1:0] count;
    } list_resp_t;

    // Traffic flavor of one random block.
    typedef enum int {
        PROF_FILL,
        PROF_DRAIN,
        PROF_LOOKUP,
        PROF_MIX
    } mix_profile_e;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               start          = 1'b0;
    logic [MODE_W-1:0]  mode           = '0;
    logic [KEY_W-1:0]   record_key     = '0;
    logic [PAY_W-1:0]   record_payload = '0;
    logic [POS_W-1:0]   position       = '0;
    logic               busy;
    logic               done;
    logic [STAT_W-1:0]  status;
    logic [KEY_W-1:0]   found_key;
    logic [PAY_W-1:0]   found_payload;
    logic [COUNT_W-1:0] entry_count;

    // Predicted list contents; only entries below list_fill are meaningful.
    logic [KEY_W-1:0] list_keys [CAPACITY];
    logic [PAY_W-1:0] list_pays [CAPACITY];
    int               list_fill = 0;

    list_req_t  pending_requests[$];
    list_resp_t expected_results[$];
    logic [KEY_W-1:0] key_pool [KEY_POOL];

    int issued_count = 0;
    int taken_count  = 0;
    int idle_left    = 0;
    int fail_count   = 0;

    ordered_array_list_engine #(
        .CAPACITY(CAPACITY)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .record_key(record_key),
        .record_payload(record_payload),
        .position(position),
        .done(done),
        .status(status),
        .found_key(found_key),
        .found_payload(found_payload),
        .entry_count(entry_count)
    );

    initial
    begin : clock_gen
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("ordered_array_list_engine_test NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // List model
    // ------------------------------------------------------------------

    // Drop the entry at 'at', shift the later ones down and shrink the list.
    function automatic void list_close_gap(input int at);
        int i;
        for (i = at; i + 1 < list_fill; i++)
        begin
            list_keys[i] = list_keys[i + 1];
            list_pays[i] = list_pays[i + 1];
        end
        list_fill--;
    endfunction

    // Apply one request to the model and return the result it must produce.
    function automatic list_resp_t list_apply(input list_req_t r);
        list_resp_t res;
        int         i;
        int         at;
        res = '0;
        if (r.mode <= MODE_INS_POS)
        begin
            if (list_fill >= CAPACITY)
                res.status = STAT_FULL_MT;
            else if (r.mode == MODE_INS_POS && int'(r.pos) > list_fill)
                res.status = STAT_BAD_POS;
            else
            begin
                // Position equal to the count is a plain append.
                if (r.mode == MODE_INS_FRONT)
                    at = 0;
                else if (r.mode == MODE_INS_BACK)
                    at = list_fill;
                else
                    at = int'(r.pos);
                for (i = list_fill; i > at; i--)
                begin
                    list_keys[i] = list_keys[i - 1];
                    list_pays[i] = list_pays[i - 1];
                end
                list_keys[at] = r.key;
                list_pays[at] = r.payload;
                list_fill++;
            end
        end
        else if (r.mode <= MODE_RM_KEY)
        begin
            if (list_fill == 0)
                res.status = STAT_FULL_MT;
            else
            begin
                case (r.mode)
                    MODE_FIND_KEY:
                    begin
                        // First match from the front.
                        at = -1;
                        for (i = 0; i < list_fill && at < 0; i++)
                            if (list_keys[i] == r.key)
                                at = i;
                        if (at < 0)
                            res.status = STAT_NO_KEY;
                        else
                        begin
                            res.key     = list_keys[at];
                            res.payload = list_pays[at];
                        end
                    end
                    MODE_READ_POS:
                    begin
                        if (int'(r.pos) >= list_fill)
                            res.status = STAT_BAD_POS;
                        else
                        begin
                            res.key     = list_keys[r.pos];
                            res.payload = list_pays[r.pos];
                        end
                    end
                    MODE_RM_FRONT:
                        list_close_gap(0);
                    MODE_RM_BACK:
                        list_fill--;
                    MODE_RM_POS:
                    begin
                        if (int'(r.pos) >= list_fill)
                            res.status = STAT_BAD_POS;
                        else
                            list_close_gap(int'(r.pos));
                    end
                    default:
                    begin
                        // Remove by key takes the last match.
                        at = -1;
                        for (i = list_fill - 1; i >= 0 && at < 0; i--)
                            if (list_keys[i] == r.key)
                                at = i;
                        if (at < 0)
                            res.status = STAT_NO_KEY;
                        else
                            list_close_gap(at);
                    end
                endcase
            end
        end
        else if (r.mode == MODE_CLEAR)
            list_fill = 0;
        // Unused modes fall through: nothing changes, status ok.
        res.count = list_fill[COUNT_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------

    function automatic void queue_request(input logic [MODE_W-1:0] m,
                                          input logic [KEY_W-1:0]  k,
                                          input logic [PAY_W-1:0]  p,
                                          input logic [POS_W-1:0]  at);
        list_req_t r;
        r.mode    = m;
        r.key     = k;
        r.payload = p;
        r.pos     = at;
        pending_requests.push_back(r);
    endfunction

    // Mostly keys from a small pool so finds and keyed removes hit, with
    // duplicates in the list; the rest fully random.
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, KEY_POOL - 1)];
        return $urandom;
    endfunction

    function automatic logic [PAY_W-1:0] pick_payload();
        return {$urandom, $urandom};
    endfunction

    // Favor low positions, which are valid at most fill levels.
    function automatic logic [POS_W-1:0] pick_pos();
        if ($urandom_range(0, 2) == 0)
            return POS_W'($urandom_range(0, (1 << POS_W) - 1));
        return POS_W'($urandom_range(0, 20));
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode(input mix_profile_e profile);
        int roll;
        roll = $urandom_range(0, 99);
        case (profile)
            PROF_FILL:
            begin
                if (roll < 85)
                    return MODE_W'($urandom_range(MODE_INS_FRONT, MODE_INS_POS));
                return MODE_W'($urandom_range(MODE_FIND_KEY, MODE_RM_KEY));
            end
            PROF_DRAIN:
            begin
                if (roll < 80)
                    return MODE_W'($urandom_range(MODE_RM_FRONT, MODE_RM_KEY));
                if (roll < 95)
                    return MODE_W'($urandom_range(MODE_FIND_KEY, MODE_READ_POS));
                return MODE_W'($urandom_range(MODE_INS_FRONT, MODE_INS_POS));
            end
            PROF_LOOKUP:
            begin
                if (roll < 70)
                    return MODE_W'($urandom_range(MODE_FIND_KEY, MODE_READ_POS));
                if (roll < 85)
                    return MODE_W'($urandom_range(MODE_INS_FRONT, MODE_INS_POS));
                return MODE_W'($urandom_range(MODE_RM_FRONT, MODE_RM_KEY));
            end
            default:
            begin
                // Mix: all list modes, plus the odd clear and unused modes.
                if (roll < 3)
                    return MODE_CLEAR;
                if (roll < 6)
                    return MODE_W'($urandom_range(MODE_CLEAR + 1, MODE_TOP));
                return MODE_W'($urandom_range(MODE_INS_FRONT, MODE_RM_KEY));
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: present the next request at the falling edge, hold it until
    // the block takes it, and insert random idle bursts between requests.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : request_driver
        list_req_t next_req;
        // Hold a request that is still waiting behind busy.
        if (rst_n && !(start && taken_count != issued_count))
        begin
            // Idle bursts after a taken request, but none in the tail.
            if (start && pending_requests.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0)
                idle_left = $urandom_range(1, IDLE_MAX);
            if (idle_left > 0)
            begin
                idle_left--;
                start <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                next_req = pending_requests.pop_front();
                mode           <= next_req.mode;
                record_key     <= next_req.key;
                record_payload <= next_req.payload;
                position       <= next_req.pos;
                start          <= 1'b1;
                issued_count++;
            end
            else
                start <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [PAY_W-1:0] want,
                               input logic [PAY_W-1:0] got);
        if (got !== want)
        begin
            if (fail_count < REPORT_MAX)
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: at each rising edge, check a result carried by done against
    // the oldest prediction, then predict for a request taken at this edge.
    // A request is never answered in the edge that takes it, so the order
    // of the two steps is safe.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        list_resp_t want;
        list_req_t  req;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                if (fail_count < REPORT_MAX)
                    $display("%0t: result with no request outstanding", $time);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", PAY_W'(want.status), PAY_W'(status));
                check_field("found_key", PAY_W'(want.key), PAY_W'(found_key));
                check_field("found_payload", want.payload, found_payload);
                check_field("entry_count", PAY_W'(want.count), PAY_W'(entry_count));
            end
        end
        if (rst_n && start && !busy)
        begin
            req = {mode, record_key, record_payload, position};
            expected_results.push_back(list_apply(req));
            taken_count++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        mix_profile_e profile;
        int           block_len;
        // Extreme keys stay in the pool; one of the rest is refreshed per block.
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < KEY_POOL; i++)
            key_pool[i] = $urandom;

        // Every lookup and remove on an empty list.
        queue_request(MODE_FIND_KEY, 32'h0000_0000, '0, '0);
        queue_request(MODE_READ_POS, 32'h0000_0000, '0, '0);
        queue_request(MODE_RM_FRONT, 32'h0000_0000, '0, '0);
        queue_request(MODE_RM_BACK, 32'h0000_0000, '0, '0);
        queue_request(MODE_RM_POS, 32'h0000_0000, '0, '0);
        queue_request(MODE_RM_KEY, 32'h0000_0000, '0, '0);
        // Positional insert beyond the count, then at the count.
        queue_request(MODE_INS_POS, 32'h0000_0001, '1, 6'd1);
        queue_request(MODE_INS_POS, 32'h8000_0000, '1, 6'd0);
        queue_request(MODE_INS_FRONT, 32'h7FFF_FFFF, '0, '1);
        // Duplicate key at the back, append by position, insert in the middle.
        queue_request(MODE_INS_BACK, 32'h8000_0000, 64'h0123_4567_89AB_CDEF, '0);
        queue_request(MODE_INS_POS, 32'h0000_0000, 64'hFEDC_BA98_7654_3210, 6'd3);
        queue_request(MODE_INS_POS, 32'hFFFF_FFFF, 64'h5555_AAAA_5555_AAAA, 6'd1);
        // First match, miss, bad and good reads.
        queue_request(MODE_FIND_KEY, 32'h8000_0000, '0, '0);
        queue_request(MODE_FIND_KEY, 32'h0000_1234, '0, '0);
        queue_request(MODE_READ_POS, 32'h0000_0000, '0, '1);
        queue_request(MODE_READ_POS, 32'h0000_0000, '0, 6'd4);
        // Keyed remove takes the last match; then a miss.
        queue_request(MODE_RM_KEY, 32'h8000_0000, '0, '0);
        queue_request(MODE_RM_KEY, 32'h0000_0055, '0, '0);
        queue_request(MODE_RM_POS, 32'h0000_0000, '0, '1);
        queue_request(MODE_RM_POS, 32'h0000_0000, '0, 6'd1);
        // Unused modes with busy fields must leave the list alone.
        queue_request(MODE_TOP, 32'hFFFF_FFFF, '1, '1);
        queue_request(MODE_W'(MODE_CLEAR + 1), 32'h8000_0000, '1, 6'd2);
        queue_request(MODE_RM_FRONT, 32'h0000_0000, '0, '0);
        queue_request(MODE_RM_BACK, 32'h0000_0000, '0, '0);
        queue_request(MODE_CLEAR, 32'h0000_0000, '0, '0);

        // Run the list into full at least once early.
        repeat (CAPACITY + 6)
            queue_request(MODE_W'($urandom_range(MODE_INS_FRONT, MODE_INS_BACK)), pick_key(),
                          pick_payload(), pick_pos());

        // Phased random traffic.
        while (pending_requests.size() < ITEM_TOTAL)
        begin
            profile = mix_profile_e'($urandom_range(PROF_FILL, PROF_MIX));
            key_pool[$urandom_range(4, KEY_POOL - 1)] = $urandom;
            block_len = $urandom_range(10, 60);
            repeat (block_len)
                queue_request(pick_mode(profile), pick_key(), pick_payload(), pick_pos());
        end

        // Hold reset, release it away from the rising edge.
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every request to be taken and answered, then let any
        // stray result show up.
        while (pending_requests.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("ordered_array_list_engine_test OK");
        else
            $display("ordered_array_list_engine_test NOT OK");
        $finish;
    end

endmodule
